// File: design/clc_pkg.sv
// Shared types and constants for the complete-linkage clustering core.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package clc_pkg;

	localparam int MAX_OBJECTS_DEF = 64;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int ID_W            = 16;
	localparam int SLOT_OUT_W      = 6;
	localparam int TGT_W           = 7;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_I_RD,
		ST_I_DX,
		ST_I_SQX,
		ST_I_SQY,
		ST_I_WR,
		ST_F_CHK,
		ST_F_RD,
		ST_F_CMP,
		ST_M_A,
		ST_M_B,
		ST_M_C,
		ST_V_A,
		ST_V_B,
		ST_S_A,
		ST_S_B,
		ST_S_END,
		ST_E_RD,
		ST_E_CMP,
		ST_E_END,
		ST_E_OUT
	} clc_state_t;

endpackage

`default_nettype wire

// File: design/clc_ifs.sv
// Valid/ready channel interfaces: point items in, result items out.
// Depends on clc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface clc_point_if import clc_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic [ID_W-1:0]      object_id;
	logic signed [CW-1:0] coord_x;
	logic signed [CW-1:0] coord_y;
	logic                 last_object;

	modport source (output valid, object_id, coord_x, coord_y, last_object, input ready);
	modport sink   (input valid, object_id, coord_x, coord_y, last_object, output ready);
endinterface

interface clc_result_if import clc_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [SLOT_OUT_W-1:0] cluster_index;
	logic [ID_W-1:0]       object_id_res;
	logic signed [CW-1:0]  coord_x_res;
	logic signed [CW-1:0]  coord_y_res;
	logic                  cluster_end;
	logic                  last;

	modport source (output valid, cluster_index, object_id_res, coord_x_res, coord_y_res,
		cluster_end, last, input ready);
	modport sink   (input valid, cluster_index, object_id_res, coord_x_res, coord_y_res,
		cluster_end, last, output ready);
endinterface

`default_nettype wire

// File: design/complete_linkage_clustering_core.sv
// Complete-linkage clustering core. Points load one item per cycle until the item flagged
// last_object; the block then drops ready and clusters. Setup computes every point-pair
// squared distance on one shared squarer. Each merge scans all cluster pairs in the linkage
// memory, rewrites two rows and relabels point slots. Output is by repeated selection: each
// result item costs one pass over the point store plus the output handshake, and each slot
// costs one extra pass to find its first point.
// Ready returns after the final result item is taken.
// Depends on clc_pkg, clc_ifs, clc_point_store and clc_link_mem.
`timescale 1ns / 1ps
`default_nettype none

module complete_linkage_clustering_core import clc_pkg::*; #(
	parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	clc_point_if.sink         points,
	clc_result_if.source      results,
	input  wire logic         target_we,
	input  wire logic [TGT_W-1:0] target_wdata
);

	localparam int IW   = $clog2(MAX_OBJECTS);
	localparam int CNTW = $clog2(MAX_OBJECTS + 1);
	localparam int DIFW = COORD_WIDTH + 1;
	localparam int DW   = 2 * DIFW;
	localparam int AW   = 2 * IW;
	localparam int KEYW = ID_W + IW;

	clc_state_t state_q, state_d;

	logic [TGT_W-1:0] tgt_q;
	logic [TGT_W-1:0] tgt_eff;
	logic [CNTW-1:0]  n_q, cc_q, a_q, b_q, k_q;
	logic [CNTW-1:0]  tail;
	logic [IW-1:0]    bf_q, bs_q, s_q;
	logic [DW-1:0]    best_q, acc_q, sq_q, tmp_q;
	logic signed [DIFW-1:0] dx_q, dy_q, mul_in;
	logic signed [DW-1:0]   mul_p;
	logic             first_q, found_q, pend_q;
	logic [KEYW-1:0]  cand_key_q, pend_key_q, last_key_q, cur_key;
	logic [COORD_WIDTH-1:0] cand_x_q, cand_y_q, pend_x_q, pend_y_q;
	logic             cand_hit;

	logic             out_valid_q;
	logic [SLOT_OUT_W-1:0] out_idx_q;
	logic [ID_W-1:0]  out_id_q;
	logic [COORD_WIDTH-1:0] out_x_q, out_y_q;
	logic             out_end_q, out_last_q;

	// store ports
	logic             pt_we, slot_we;
	logic [IW-1:0]    slot_waddr, slot_wdata, raddr_a, raddr_b;
	logic [ID_W-1:0]  rid_a;
	logic [COORD_WIDTH-1:0] rx_a, ry_a, rx_b, ry_b;
	logic [IW-1:0]    rslot_a;
	logic             lk_we;
	logic [AW-1:0]    lk_waddr, lk_raddr;
	logic [DW-1:0]    lk_wdata, lk_rdata;

	logic in_acc, out_acc;

	function automatic logic [AW-1:0] pair_addr(logic [IW-1:0] p, logic [IW-1:0] q);
		return (p < q) ? {p, q} : {q, p};
	endfunction

	clc_point_store #(.N(MAX_OBJECTS), .CW(COORD_WIDTH)) u_points (
		.clk       (clk),
		.we        (pt_we),
		.waddr     (n_q[IW-1:0]),
		.wid       (points.object_id),
		.wx        (points.coord_x),
		.wy        (points.coord_y),
		.slot_we   (slot_we),
		.slot_waddr(slot_waddr),
		.slot_wdata(slot_wdata),
		.raddr_a   (raddr_a),
		.raddr_b   (raddr_b),
		.rid_a     (rid_a),
		.rx_a      (rx_a),
		.ry_a      (ry_a),
		.rslot_a   (rslot_a),
		.rx_b      (rx_b),
		.ry_b      (ry_b)
	);

	clc_link_mem #(.N(MAX_OBJECTS), .DW(DW)) u_link (
		.clk  (clk),
		.we   (lk_we),
		.waddr(lk_waddr),
		.wdata(lk_wdata),
		.raddr(lk_raddr),
		.rdata(lk_rdata)
	);

	assign tgt_eff = (tgt_q == '0) ? TGT_W'(1) : tgt_q;
	assign tail    = cc_q - CNTW'(1);
	assign in_acc  = points.valid && points.ready;
	assign out_acc = results.valid && results.ready;

	// shared squarer
	assign mul_in = (state_q == ST_I_SQX) ? dx_q : dy_q;
	assign mul_p  = mul_in * mul_in;

	assign cur_key  = {rid_a, k_q[IW-1:0]};
	assign cand_hit = (rslot_a == s_q) && (first_q || cur_key > last_key_q)
		&& (!found_q || cur_key < cand_key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		points.ready  = 1'b0;
		pt_we         = 1'b0;
		slot_we       = 1'b0;
		slot_waddr    = k_q[IW-1:0];
		slot_wdata    = rslot_a;
		raddr_a       = k_q[IW-1:0];
		raddr_b       = b_q[IW-1:0];
		lk_we         = 1'b0;
		lk_waddr      = pair_addr(a_q[IW-1:0], b_q[IW-1:0]);
		lk_wdata      = acc_q + sq_q;
		lk_raddr      = pair_addr(a_q[IW-1:0], b_q[IW-1:0]);
		unique case (state_q)
			ST_LOAD: begin
				points.ready = 1'b1;
				if (in_acc) begin
					if (32'(n_q) < MAX_OBJECTS) begin
						pt_we      = 1'b1;
						slot_we    = 1'b1;
						slot_waddr = n_q[IW-1:0];
						slot_wdata = n_q[IW-1:0];
					end
					if (points.last_object) begin
						state_d = ST_I_RD;
					end
				end
			end
			ST_I_RD: begin
				raddr_a = a_q[IW-1:0];
				if (a_q + CNTW'(1) >= n_q) begin
					state_d = ST_F_CHK;
				end else if (b_q < n_q) begin
					state_d = ST_I_DX;
				end
			end
			ST_I_DX:  state_d = ST_I_SQX;
			ST_I_SQX: state_d = ST_I_SQY;
			ST_I_SQY: state_d = ST_I_WR;
			ST_I_WR: begin
				lk_we   = 1'b1;
				state_d = ST_I_RD;
			end
			ST_F_CHK: begin
				if (32'(cc_q) > 32'(tgt_eff)) begin
					state_d = ST_F_RD;
				end else begin
					state_d = ST_E_RD;
				end
			end
			ST_F_RD: begin
				if (a_q + CNTW'(1) >= cc_q) begin
					state_d = ST_M_A;
				end else if (b_q < cc_q) begin
					state_d = ST_F_CMP;
				end
			end
			ST_F_CMP: state_d = ST_F_RD;
			ST_M_A: begin
				lk_raddr = pair_addr(bf_q, k_q[IW-1:0]);
				if (k_q >= cc_q) begin
					state_d = ST_V_A;
				end else if (k_q[IW-1:0] != bf_q && k_q[IW-1:0] != bs_q) begin
					state_d = ST_M_B;
				end
			end
			ST_M_B: begin
				lk_raddr = pair_addr(bs_q, k_q[IW-1:0]);
				state_d  = ST_M_C;
			end
			ST_M_C: begin
				lk_we    = 1'b1;
				lk_waddr = pair_addr(bf_q, k_q[IW-1:0]);
				lk_wdata = (lk_rdata > tmp_q) ? lk_rdata : tmp_q;
				state_d  = ST_M_A;
			end
			ST_V_A: begin
				lk_raddr = pair_addr(tail[IW-1:0], k_q[IW-1:0]);
				if (k_q >= tail) begin
					state_d = ST_S_A;
				end else if (k_q[IW-1:0] != bs_q) begin
					state_d = ST_V_B;
				end
			end
			ST_V_B: begin
				lk_we    = 1'b1;
				lk_waddr = pair_addr(bs_q, k_q[IW-1:0]);
				lk_wdata = lk_rdata;
				state_d  = ST_V_A;
			end
			ST_S_A: begin
				if (k_q >= n_q) begin
					state_d = ST_S_END;
				end else begin
					state_d = ST_S_B;
				end
			end
			ST_S_B: begin
				slot_we = 1'b1;
				// second cluster folds into the first, tail cluster takes the freed slot
				if (rslot_a == bs_q) begin
					slot_wdata = bf_q;
				end else if (rslot_a == tail[IW-1:0]) begin
					slot_wdata = bs_q;
				end
				state_d = ST_S_A;
			end
			ST_S_END: state_d = ST_F_CHK;
			ST_E_RD: begin
				if (k_q >= n_q) begin
					state_d = ST_E_END;
				end else begin
					state_d = ST_E_CMP;
				end
			end
			ST_E_CMP: state_d = ST_E_RD;
			ST_E_END: begin
				if (pend_q) begin
					state_d = ST_E_OUT;
				end else if (found_q) begin
					state_d = ST_E_RD;
				end else begin
					state_d = ST_LOAD;
				end
			end
			ST_E_OUT: begin
				if (out_acc) begin
					if (!found_q && CNTW'(s_q) + CNTW'(1) == cc_q) begin
						state_d = ST_LOAD;
					end else begin
						state_d = ST_E_RD;
					end
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q       <= TGT_W'(1);
			n_q         <= '0;
			cc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (target_we) begin
				tgt_q <= target_wdata;
			end
			if (state_q == ST_LOAD && in_acc && 32'(n_q) < MAX_OBJECTS) begin
				n_q  <= n_q + CNTW'(1);
				cc_q <= n_q + CNTW'(1);
			end
			if (state_q == ST_S_END) begin
				cc_q <= tail;
			end
			if (state_q == ST_E_END && pend_q) begin
				out_valid_q <= 1'b1;
			end
			if (state_q == ST_E_OUT && out_acc) begin
				out_valid_q <= 1'b0;
				if (!found_q && CNTW'(s_q) + CNTW'(1) == cc_q) begin
					n_q  <= '0;
					cc_q <= '0;
				end
			end
			if (state_q == ST_E_END && !pend_q && !found_q) begin
				n_q  <= '0;
				cc_q <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				a_q <= '0;
				b_q <= CNTW'(1);
			end
			ST_I_RD: begin
				if (b_q >= n_q) begin
					a_q <= a_q + CNTW'(1);
					b_q <= a_q + CNTW'(2);
				end
			end
			ST_I_DX: begin
				dx_q <= $signed({rx_a[COORD_WIDTH-1], rx_a}) - $signed({rx_b[COORD_WIDTH-1], rx_b});
				dy_q <= $signed({ry_a[COORD_WIDTH-1], ry_a}) - $signed({ry_b[COORD_WIDTH-1], ry_b});
			end
			ST_I_SQX: sq_q <= $unsigned(mul_p);
			ST_I_SQY: begin
				acc_q <= sq_q;
				sq_q  <= $unsigned(mul_p);
			end
			ST_I_WR: b_q <= b_q + CNTW'(1);
			ST_F_CHK: begin
				a_q     <= '0;
				b_q     <= CNTW'(1);
				best_q  <= '1;
				bf_q    <= '0;
				bs_q    <= '0;
				k_q     <= '0;
				s_q     <= '0;
				first_q <= 1'b1;
				found_q <= 1'b0;
				pend_q  <= 1'b0;
			end
			ST_F_RD: begin
				k_q <= '0;
				if (b_q >= cc_q) begin
					a_q <= a_q + CNTW'(1);
					b_q <= a_q + CNTW'(2);
				end
			end
			ST_F_CMP: begin
				if (lk_rdata < best_q) begin
					best_q <= lk_rdata;
					bf_q   <= a_q[IW-1:0];
					bs_q   <= b_q[IW-1:0];
				end
				b_q <= b_q + CNTW'(1);
			end
			ST_M_A: begin
				if (k_q >= cc_q) begin
					k_q <= '0;
				end else if (k_q[IW-1:0] == bf_q || k_q[IW-1:0] == bs_q) begin
					k_q <= k_q + CNTW'(1);
				end
			end
			ST_M_B: tmp_q <= lk_rdata;
			ST_M_C: k_q <= k_q + CNTW'(1);
			ST_V_A: begin
				if (k_q >= tail) begin
					k_q <= '0;
				end else if (k_q[IW-1:0] == bs_q) begin
					k_q <= k_q + CNTW'(1);
				end
			end
			ST_V_B: k_q <= k_q + CNTW'(1);
			ST_S_B: k_q <= k_q + CNTW'(1);
			ST_E_CMP: begin
				if (cand_hit) begin
					found_q    <= 1'b1;
					cand_key_q <= cur_key;
					cand_x_q   <= rx_a;
					cand_y_q   <= ry_a;
				end
				k_q <= k_q + CNTW'(1);
			end
			ST_E_END: begin
				if (pend_q) begin
					out_idx_q  <= SLOT_OUT_W'(s_q);
					out_id_q   <= pend_key_q[KEYW-1:IW];
					out_x_q    <= pend_x_q;
					out_y_q    <= pend_y_q;
					out_end_q  <= !found_q;
					out_last_q <= !found_q && (CNTW'(s_q) + CNTW'(1) == cc_q);
				end else if (found_q) begin
					pend_q     <= 1'b1;
					pend_key_q <= cand_key_q;
					pend_x_q   <= cand_x_q;
					pend_y_q   <= cand_y_q;
					last_key_q <= cand_key_q;
					first_q    <= 1'b0;
					found_q    <= 1'b0;
					k_q        <= '0;
				end
			end
			ST_E_OUT: begin
				if (out_acc) begin
					k_q <= '0;
					if (found_q) begin
						pend_key_q <= cand_key_q;
						pend_x_q   <= cand_x_q;
						pend_y_q   <= cand_y_q;
						last_key_q <= cand_key_q;
						found_q    <= 1'b0;
					end else begin
						// slot finished: next slot starts a fresh selection
						pend_q  <= 1'b0;
						first_q <= 1'b1;
						s_q     <= s_q + IW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign results.valid         = out_valid_q;
	assign results.cluster_index = out_idx_q;
	assign results.object_id_res = out_id_q;
	assign results.coord_x_res   = out_x_q;
	assign results.coord_y_res   = out_y_q;
	assign results.cluster_end   = out_end_q;
	assign results.last          = out_last_q;

	a_out_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> state_q == ST_E_OUT)
		else $error("result valid outside output state");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		points.ready |-> !results.valid)
		else $error("input ready while a result is pending");

	a_cc_le_n: assert property (@(posedge clk) disable iff (!arst_n)
		cc_q <= n_q)
		else $error("cluster count above point count");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_M_A |-> bf_q < bs_q)
		else $error("merge pair out of order");

endmodule

`default_nettype wire

// File: design/clc_point_store.sv
// Point store: id, coordinates and cluster slot per loaded point.
// Two registered read ports (A full record, B coordinates). Depends on clc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clc_point_store import clc_pkg::*; #(
	parameter int N  = MAX_OBJECTS_DEF,
	parameter int CW = COORD_WIDTH_DEF,
	localparam int IW = $clog2(N)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [IW-1:0] waddr,
	input  wire logic [ID_W-1:0] wid,
	input  wire logic [CW-1:0] wx,
	input  wire logic [CW-1:0] wy,
	input  wire logic          slot_we,
	input  wire logic [IW-1:0] slot_waddr,
	input  wire logic [IW-1:0] slot_wdata,
	input  wire logic [IW-1:0] raddr_a,
	input  wire logic [IW-1:0] raddr_b,
	output logic [ID_W-1:0]    rid_a,
	output logic [CW-1:0]      rx_a,
	output logic [CW-1:0]      ry_a,
	output logic [IW-1:0]      rslot_a,
	output logic [CW-1:0]      rx_b,
	output logic [CW-1:0]      ry_b
);

	logic [ID_W-1:0] id_mem   [N];
	logic [CW-1:0]   x_mem    [N];
	logic [CW-1:0]   y_mem    [N];
	logic [IW-1:0]   slot_mem [N];

	always_ff @(posedge clk) begin
		if (we) begin
			id_mem[waddr] <= wid;
			x_mem[waddr]  <= wx;
			y_mem[waddr]  <= wy;
		end
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
	end

	always_ff @(posedge clk) begin
		rid_a   <= id_mem[raddr_a];
		rx_a    <= x_mem[raddr_a];
		ry_a    <= y_mem[raddr_a];
		rslot_a <= slot_mem[raddr_a];
		rx_b    <= x_mem[raddr_b];
		ry_b    <= y_mem[raddr_b];
	end

endmodule

`default_nettype wire

// File: design/clc_link_mem.sv
// Cluster-pair linkage distance memory, addressed by {lower slot, higher slot}.
// One write port, one registered read port. Depends on clc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clc_link_mem import clc_pkg::*; #(
	parameter int N  = MAX_OBJECTS_DEF,
	parameter int DW = 2 * (COORD_WIDTH_DEF + 1),
	localparam int AW = 2 * $clog2(N)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic [DW-1:0]      rdata
);

	// full address space: {p, q} spans 2**AW even when N is not a power of two
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
